// File: hdl/tri2d_pkg.sv
`timescale 1ns / 1ps
package tri2d_pkg;

    // Field widths
    localparam int TAG_W    = 8;
    localparam int COORD_W  = 16;
    localparam int RANGE_W  = 16;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR1_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR1_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR2_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR2_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR3_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR3_Y = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED  = 2'd2;

    // Datapath widths
    localparam int COEF_W = 18;   // 2*(xi-x1)
    localparam int SQ_W   = 32;   // squares of 16-bit values
    localparam int EF_W   = 34;   // right-hand sides
    localparam int PROD_W = 36;   // a*d, b*c, det
    localparam int MUL_W  = 52;   // e*d, b*f, a*f, e*c
    localparam int NUM_W  = 53;   // Cramer numerators and their magnitudes

    // Quotient bits kept; the top shift only flags overflow
    localparam int DIV_TOP = 17;
    localparam int DIV_STAGES = DIV_TOP + 1;
    localparam int SH_W = 5;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              degen;
        logic              neg_x;
        logic              neg_y;
        logic [NUM_W-1:0]  rem_x;
        logic [NUM_W-1:0]  rem_y;
        logic [DIV_TOP-1:0] q_x;
        logic [DIV_TOP-1:0] q_y;
        logic              big_x;
        logic              big_y;
        logic [PROD_W-1:0] dm;
    } div_t;

endpackage

// File: hdl/tri2d_range_if.sv
`timescale 1ns / 1ps
interface tri2d_range_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tag_id;
    logic [15:0] range_one;
    logic [15:0] range_two;
    logic [15:0] range_three;

    modport source (output valid, tag_id, range_one, range_two, range_three, input ready);
    modport sink (input valid, tag_id, range_one, range_two, range_three, output ready);
endinterface

// File: hdl/tri2d_pos_if.sv
`timescale 1ns / 1ps
interface tri2d_pos_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tag_out;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [1:0]  status;

    modport source (output valid, tag_out, pos_x, pos_y, status, input ready);
    modport sink (input valid, tag_out, pos_x, pos_y, status, output ready);
endinterface

// File: hdl/tri2d_div.sv
`timescale 1ns / 1ps
module tri2d_div
    import tri2d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    div_t st_reg [0:DIV_STAGES-1];
    logic [DIV_STAGES-1:0] vld_reg;
    div_t st_next [0:DIV_STAGES-1];

    // One restoring step on both quotients at a fixed shift
    function automatic div_t div_step(div_t s, logic [SH_W-1:0] sh);
        div_t o;
        logic [NUM_W:0] dsh;
        o = s;
        dsh = {{(NUM_W+1-PROD_W){1'b0}}, s.dm} << sh;
        if ({1'b0, s.rem_x} >= dsh) begin
            if (sh == SH_W'(DIV_TOP)) begin
                o.big_x = 1'b1;
            end
            else begin
                o.rem_x = NUM_W'({1'b0, s.rem_x} - dsh);
                o.q_x[sh] = 1'b1;
            end
        end
        if ({1'b0, s.rem_y} >= dsh) begin
            if (sh == SH_W'(DIV_TOP)) begin
                o.big_y = 1'b1;
            end
            else begin
                o.rem_y = NUM_W'({1'b0, s.rem_y} - dsh);
                o.q_y[sh] = 1'b1;
            end
        end
        return o;
    endfunction

    // Step logic, one shift per stage from the top down
    always_comb
    begin
        st_next[0] = div_step(in_data, SH_W'(DIV_TOP));
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            st_next[k] = div_step(st_reg[k-1], SH_W'(DIV_TOP - k));
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_data  = st_reg[DIV_STAGES-1];

endmodule

// File: hdl/trilateration_2d_three_anchors_top.sv
`timescale 1ns / 1ps
// Channel    Dir  Payload
// ranges     in   tag_id, range_one, range_two, range_three
// position   out  tag_out, pos_x, pos_y, status
// cfg_*      in   write enable, register index, 16-bit data
//
// One transaction per cycle while the skid register is empty; a result passes
// through five arithmetic stages, an 18-stage restoring divider (one quotient
// bit per stage below the top one, which only flags overflow) and the output register.
// Reset clears the anchor registers and all valid bits.
// A result that meets a stalled output moves into a skid register; once that
// is full every stage freezes at once, so ranges.ready comes from a register.
module trilateration_2d_three_anchors_top
    import tri2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tri2d_range_if.sink           ranges,
    tri2d_pos_if.source           position
);

    // Anchor registers
    logic signed [COORD_W-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax1_reg <= '0;
            ay1_reg <= '0;
            ax2_reg <= '0;
            ay2_reg <= '0;
            ax3_reg <= '0;
            ay3_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANCHOR1_X: ax1_reg <= cfg_data;
                REG_ANCHOR1_Y: ay1_reg <= cfg_data;
                REG_ANCHOR2_X: ax2_reg <= cfg_data;
                REG_ANCHOR2_Y: ay2_reg <= cfg_data;
                REG_ANCHOR3_X: ax3_reg <= cfg_data;
                REG_ANCHOR3_Y: ay3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: move everything unless the skid register holds a result
    logic out_valid_reg;
    logic skid_valid_reg;
    logic out_free;
    logic adv;
    assign out_free = !out_valid_reg || position.ready;
    assign adv = !skid_valid_reg;
    assign ranges.ready = adv;

    logic [5:1] vld_reg;
    logic div_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:1], ranges.valid};
        end
    end

    // Stage 1: coefficients and squares
    logic [TAG_W-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [COEF_W-1:0] a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [SQ_W-1:0] x1sq_reg, y1sq_reg, x2sq_reg, y2sq_reg, x3sq_reg, y3sq_reg;
    logic [SQ_W-1:0] r1sq_reg, r2sq_reg, r3sq_reg;
    logic signed [COORD_W:0] dxa, dya, dxc, dyc;

    assign dxa = {ax2_reg[COORD_W-1], ax2_reg} - {ax1_reg[COORD_W-1], ax1_reg};
    assign dya = {ay2_reg[COORD_W-1], ay2_reg} - {ay1_reg[COORD_W-1], ay1_reg};
    assign dxc = {ax3_reg[COORD_W-1], ax3_reg} - {ax1_reg[COORD_W-1], ax1_reg};
    assign dyc = {ay3_reg[COORD_W-1], ay3_reg} - {ay1_reg[COORD_W-1], ay1_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg   <= ranges.tag_id;
            a1_reg   <= {dxa, 1'b0};
            b1_reg   <= {dya, 1'b0};
            c1_reg   <= {dxc, 1'b0};
            d1_reg   <= {dyc, 1'b0};
            x1sq_reg <= ax1_reg * ax1_reg;
            y1sq_reg <= ay1_reg * ay1_reg;
            x2sq_reg <= ax2_reg * ax2_reg;
            y2sq_reg <= ay2_reg * ay2_reg;
            x3sq_reg <= ax3_reg * ax3_reg;
            y3sq_reg <= ay3_reg * ay3_reg;
            r1sq_reg <= ranges.range_one * ranges.range_one;
            r2sq_reg <= ranges.range_two * ranges.range_two;
            r3sq_reg <= ranges.range_three * ranges.range_three;
        end
    end

    // Stage 2: right-hand sides and the determinant products
    logic signed [EF_W-1:0] k1, k2, k3, e_next, f_next;
    logic signed [EF_W-1:0] e2_reg, f2_reg;
    logic signed [COEF_W-1:0] a2_reg, b2_reg, c2_reg, d2_reg;
    logic signed [PROD_W-1:0] ad2_reg, bc2_reg;

    assign k1 = EF_W'(x1sq_reg) + EF_W'(y1sq_reg);
    assign k2 = EF_W'(x2sq_reg) + EF_W'(y2sq_reg);
    assign k3 = EF_W'(x3sq_reg) + EF_W'(y3sq_reg);
    assign e_next = $signed({2'b00, r1sq_reg}) - $signed({2'b00, r2sq_reg}) - k1 + k2;
    assign f_next = $signed({2'b00, r1sq_reg}) - $signed({2'b00, r3sq_reg}) - k1 + k3;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t2_reg  <= t1_reg;
            e2_reg  <= e_next;
            f2_reg  <= f_next;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            c2_reg  <= c1_reg;
            d2_reg  <= d1_reg;
            ad2_reg <= a1_reg * d1_reg;
            bc2_reg <= b1_reg * c1_reg;
        end
    end

    // Stage 3: determinant and numerator products
    logic signed [PROD_W-1:0] det3_reg;
    logic signed [MUL_W-1:0] ed3_reg, bf3_reg, af3_reg, ec3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t3_reg   <= t2_reg;
            det3_reg <= ad2_reg - bc2_reg;
            ed3_reg  <= e2_reg * d2_reg;
            bf3_reg  <= b2_reg * f2_reg;
            af3_reg  <= a2_reg * f2_reg;
            ec3_reg  <= e2_reg * c2_reg;
        end
    end

    // Stage 4: Cramer numerators
    logic signed [PROD_W-1:0] det4_reg;
    logic signed [NUM_W-1:0] nx4_reg, ny4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t4_reg   <= t3_reg;
            det4_reg <= det3_reg;
            nx4_reg  <= NUM_W'(ed3_reg) - NUM_W'(bf3_reg);
            ny4_reg  <= NUM_W'(af3_reg) - NUM_W'(ec3_reg);
        end
    end

    // Stage 5: signs and magnitudes for the divider
    div_t div_in_reg;
    div_t div_out;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_in_reg.tag   <= t4_reg;
            div_in_reg.degen <= (det4_reg == '0);
            div_in_reg.neg_x <= nx4_reg[NUM_W-1] ^ det4_reg[PROD_W-1];
            div_in_reg.neg_y <= ny4_reg[NUM_W-1] ^ det4_reg[PROD_W-1];
            div_in_reg.rem_x <= nx4_reg[NUM_W-1] ? NUM_W'(-nx4_reg) : NUM_W'(nx4_reg);
            div_in_reg.rem_y <= ny4_reg[NUM_W-1] ? NUM_W'(-ny4_reg) : NUM_W'(ny4_reg);
            div_in_reg.q_x   <= '0;
            div_in_reg.q_y   <= '0;
            div_in_reg.big_x <= 1'b0;
            div_in_reg.big_y <= 1'b0;
            div_in_reg.dm    <= det4_reg[PROD_W-1] ? PROD_W'(-det4_reg)
                                                   : PROD_W'(det4_reg);
        end
    end

    tri2d_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (vld_reg[5]),
        .in_data  (div_in_reg),
        .out_valid(div_valid),
        .out_data (div_out)
    );

    // Output: apply sign, clamp and pick the status
    logic [DIV_TOP-1:0] qx, qy;
    logic sat_x, sat_y;
    logic [COORD_W-1:0] px_next, py_next;
    logic [STATUS_W-1:0] status_next;

    assign qx = div_out.q_x;
    assign qy = div_out.q_y;

    always_comb
    begin
        if (div_out.neg_x)
        begin
            sat_x   = div_out.big_x || (qx > DIV_TOP'(32768));
            px_next = sat_x ? 16'h8000 : COORD_W'(-qx);
        end
        else
        begin
            sat_x   = div_out.big_x || (qx > DIV_TOP'(32767));
            px_next = sat_x ? 16'h7fff : qx[COORD_W-1:0];
        end
        if (div_out.neg_y)
        begin
            sat_y   = div_out.big_y || (qy > DIV_TOP'(32768));
            py_next = sat_y ? 16'h8000 : COORD_W'(-qy);
        end
        else
        begin
            sat_y   = div_out.big_y || (qy > DIV_TOP'(32767));
            py_next = sat_y ? 16'h7fff : qy[COORD_W-1:0];
        end
        if (div_out.degen)
        begin
            px_next     = '0;
            py_next     = '0;
            status_next = STATUS_DEGENERATE;
        end
        else if (sat_x || sat_y)
        begin
            status_next = STATUS_SATURATED;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    logic [TAG_W-1:0] tag_out_reg, skid_tag_reg;
    logic [COORD_W-1:0] pos_x_reg, pos_y_reg, skid_x_reg, skid_y_reg;
    logic [STATUS_W-1:0] status_reg, skid_status_reg;

    // Refill the output from the skid register first; park a result there on a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || div_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            skid_valid_reg <= div_valid;
        end
    end

    // Hold the result while the sink stalls
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                tag_out_reg <= skid_tag_reg;
                pos_x_reg   <= skid_x_reg;
                pos_y_reg   <= skid_y_reg;
                status_reg  <= skid_status_reg;
            end
            else
            begin
                tag_out_reg <= div_out.tag;
                pos_x_reg   <= px_next;
                pos_y_reg   <= py_next;
                status_reg  <= status_next;
            end
        end
        else if (adv)
        begin
            skid_tag_reg    <= div_out.tag;
            skid_x_reg      <= px_next;
            skid_y_reg      <= py_next;
            skid_status_reg <= status_next;
        end
    end

    assign position.valid   = out_valid_reg;
    assign position.tag_out = tag_out_reg;
    assign position.pos_x   = pos_x_reg;
    assign position.pos_y   = pos_y_reg;
    assign position.status  = status_reg;

endmodule

// File: tb/tb_trilateration_2d_three_anchors_top.sv
`timescale 1ns / 1ps
module tb_trilateration_2d_three_anchors_top;
    import tri2d_pkg::*;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [STATUS_W-1:0] status;
    } fix_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tri2d_range_if ranges ();
    tri2d_pos_if position ();

    trilateration_2d_three_anchors_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .ranges(ranges.sink),
        .position(position.source)
    );

    // Anchor registers as the block should hold them
    logic signed [15:0] anchor_reg [6];
    fix_t pending_fixes [$];
    int mismatches = 0;
    longint cycle = 0;
    bit hold_receiver = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Limit the run length
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > 400000)
        begin
            $display("** trilateration_2d_three_anchors_top: FAILED **");
            $finish;
        end
    end

    function automatic longint clamp_coord(longint v, ref bit sat);
        if (v > 32767)
        begin
            sat = 1;
            return 32767;
        end
        if (v < -32768)
        begin
            sat = 1;
            return -32768;
        end
        return v;
    endfunction

    // Solve the position by Cramer's rule with truncating division
    function automatic fix_t solve_position(logic [7:0] tag, logic [15:0] r1u,
                                            logic [15:0] r2u, logic [15:0] r3u);
        longint x1, y1, x2, y2, x3, y3, r1, r2, r3, k1, k2, k3;
        longint a, b, c, d, e, f, det, px, py;
        bit sat;
        fix_t res;
        x1 = anchor_reg[0]; y1 = anchor_reg[1];
        x2 = anchor_reg[2]; y2 = anchor_reg[3];
        x3 = anchor_reg[4]; y3 = anchor_reg[5];
        r1 = r1u; r2 = r2u; r3 = r3u;
        k1 = x1 * x1 + y1 * y1;
        k2 = x2 * x2 + y2 * y2;
        k3 = x3 * x3 + y3 * y3;
        a = 2 * (x2 - x1); b = 2 * (y2 - y1);
        c = 2 * (x3 - x1); d = 2 * (y3 - y1);
        e = r1 * r1 - r2 * r2 - k1 + k2;
        f = r1 * r1 - r3 * r3 - k1 + k3;
        det = a * d - b * c;
        sat = 0;
        px = 0;
        py = 0;
        res.tag = tag;
        if (det == 0)
            res.status = STATUS_DEGENERATE;
        else
        begin
            px = clamp_coord((e * d - b * f) / det, sat);
            py = clamp_coord((a * f - e * c) / det, sat);
            res.status = sat ? STATUS_SATURATED : STATUS_OK;
        end
        res.x = px[15:0];
        res.y = py[15:0];
        return res;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx < 6)
            anchor_reg[idx] = val;
    endtask

    task automatic set_anchors(logic [15:0] ax1, logic [15:0] ay1, logic [15:0] ax2,
                               logic [15:0] ay2, logic [15:0] ax3, logic [15:0] ay3);
        write_reg(REG_ANCHOR1_X, ax1);
        write_reg(REG_ANCHOR1_Y, ay1);
        write_reg(REG_ANCHOR2_X, ax2);
        write_reg(REG_ANCHOR2_Y, ay2);
        write_reg(REG_ANCHOR3_X, ax3);
        write_reg(REG_ANCHOR3_Y, ay3);
    endtask

    // Wait for the pipeline to drain before touching the anchors
    task automatic drain;
        while (pending_fixes.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // Send one transaction, with an optional random gap first
    task automatic send_ranges(logic [7:0] tag, logic [15:0] r1, logic [15:0] r2,
                               logic [15:0] r3, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(19, 0) : 0;
        if ($urandom_range(3, 0) == 0)
            gap = 0;
        if (gap != 0)
        begin
            ranges.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ranges.valid <= 1'b1;
        ranges.tag_id <= tag;
        ranges.range_one <= r1;
        ranges.range_two <= r2;
        ranges.range_three <= r3;
        pending_fixes.push_back(solve_position(tag, r1, r2, r3));
        do
            @(posedge clk);
        while (!ranges.ready);
        @(negedge clk);
    endtask

    task automatic idle_input;
        ranges.valid <= 1'b0;
    endtask

    // Position a tag from a random point so ranges are consistent
    task automatic send_consistent(bit gaps);
        longint px, py, dx, dy;
        logic [15:0] r [3];
        px = $signed($urandom_range(4000, 0)) - 2000;
        py = $signed($urandom_range(4000, 0)) - 2000;
        for (int i = 0; i < 3; i++)
        begin
            dx = px - anchor_reg[2 * i];
            dy = py - anchor_reg[2 * i + 1];
            r[i] = 16'($rtoi($sqrt(real'(dx * dx + dy * dy))));
        end
        send_ranges(8'($urandom_range(255, 0)), r[0], r[1], r[2], gaps);
    endtask

    task automatic test_extremes;
        set_anchors(16'd0, 16'd0, 16'd1000, 16'd0, 16'd0, 16'd1000);
        send_ranges(8'h00, 16'd0, 16'd0, 16'd0, 0);
        send_ranges(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_ranges(8'hA5, 16'hFFFF, 16'd0, 16'd0, 0);
        send_ranges(8'h5A, 16'd0, 16'hFFFF, 16'd0, 0);
        send_ranges(8'h3C, 16'd0, 16'd0, 16'hFFFF, 0);
        send_ranges(8'h01, 16'd707, 16'd707, 16'd707, 0);
        idle_input();
        drain();
        // Anchors at the far corners of the coordinate range
        set_anchors(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_ranges(8'h11, 16'hFFFF, 16'd0, 16'd0, 0);
        send_ranges(8'h12, 16'd0, 16'hFFFF, 16'hFFFF, 0);
        send_ranges(8'h13, 16'h8000, 16'h8000, 16'h8000, 0);
        idle_input();
        drain();
    endtask

    task automatic test_degenerate;
        // Reset anchors all at the origin
        set_anchors(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_ranges(8'h21, 16'd100, 16'd200, 16'd300, 0);
        idle_input();
        drain();
        // Collinear anchors, and anchors 1 and 2 sharing y
        set_anchors(16'd0, 16'd0, 16'd100, 16'd100, 16'd200, 16'd200);
        send_ranges(8'h22, 16'd50, 16'd60, 16'd70, 0);
        idle_input();
        drain();
        set_anchors(16'd0, 16'd5, 16'd300, 16'd5, 16'hFF00, 16'd900);
        send_ranges(8'h23, 16'd400, 16'd500, 16'd600, 0);
        send_ranges(8'h24, 16'd1, 16'd2, 16'd3, 0);
        idle_input();
        drain();
        // Writes to unused indexes are dropped
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'hFFFF);
        send_ranges(8'h25, 16'd400, 16'd500, 16'd600, 0);
        idle_input();
        drain();
    endtask

    task automatic test_random_traffic;
        for (int p = 0; p < 5; p++)
        begin
            if (p == 4)
                set_anchors(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom));
            else
                set_anchors(16'($urandom_range(3000, 0)), 16'($urandom_range(3000, 0)),
                            16'($urandom_range(3000, 0)), 16'($urandom_range(3000, 0)),
                            16'($urandom_range(3000, 0)), 16'($urandom_range(3000, 0)));
            for (int i = 0; i < 190; i++)
            begin
                if ($urandom_range(4, 0) == 0)
                    send_ranges(8'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), p != 2);
                else
                    send_consistent(p != 2);
            end
            idle_input();
            drain();
        end
    endtask

    task automatic test_backpressure;
        set_anchors(16'd0, 16'd0, 16'd2000, 16'd0, 16'd0, 16'd2000);
        hold_receiver = 1;
        for (int i = 0; i < 60; i++)
            send_consistent(0);
        idle_input();
        // Pause until every position is back
        drain();
        for (int i = 0; i < 40; i++)
            send_consistent(0);
        idle_input();
        drain();
    endtask

    // Receiver: random stalls, with one long hold-off on request
    initial
    begin
        int wait_cycles;
        position.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_receiver)
            begin
                position.ready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_receiver = 0;
            end
            wait_cycles = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(19, 0);
            if (wait_cycles != 0)
            begin
                position.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            position.ready <= 1'b1;
            do
                @(posedge clk);
            while (!position.valid);
        end
    end

    // Check each accepted position against the oldest prediction
    always @(posedge clk)
    begin
        fix_t want;
        if (rst_n && position.valid && position.ready)
        begin
            if (pending_fixes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected position: tag %0d", position.tag_out);
            end
            else
            begin
                want = pending_fixes.pop_front();
                if (want.tag !== position.tag_out || want.x !== position.pos_x ||
                    want.y !== position.pos_y || want.status !== position.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want tag %0d x %0d y %0d st %0d, got %0d %0d %0d %0d",
                                 want.tag, $signed(want.x), $signed(want.y), want.status,
                                 position.tag_out, $signed(position.pos_x),
                                 $signed(position.pos_y), position.status);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        ranges.valid = 1'b0;
        ranges.tag_id = '0;
        ranges.range_one = '0;
        ranges.range_two = '0;
        ranges.range_three = '0;
        for (int i = 0; i < 6; i++)
            anchor_reg[i] = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_degenerate();
        test_extremes();
        test_backpressure();
        test_random_traffic();
        if (pending_fixes.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("** trilateration_2d_three_anchors_top: PASSED **");
        else
            $display("** trilateration_2d_three_anchors_top: FAILED **");
        $finish;
    end
endmodule
